[sv/lcabl_pkg.sv]
// shared types and constants for the lca binary-lifting block
// used by lcabl_mem, lcabl_ctrl and lca_binary_lifting; no dependencies
package lcabl_pkg;

  localparam int NODE_W          = 10;
  localparam int DEPTH_W         = 10;
  localparam int LVL_W           = 4;
  localparam int DIFF_W          = 1 << LVL_W;
  localparam int NODE_COUNT_DEF  = 1024;
  localparam int LIFT_LEVELS_DEF = 10;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  localparam logic CMD_ATTACH = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_ATT_RD,
    ST_ATT_WR,
    ST_ATT_LOOK,
    ST_ATT_FILL,
    ST_Q_DA,
    ST_Q_DB,
    ST_Q_SWAP,
    ST_Q_LIFT,
    ST_Q_LIFTD,
    ST_Q_EQ,
    ST_Q_PA,
    ST_Q_PB,
    ST_Q_CMP,
    ST_Q_FIN,
    ST_Q_RES
  } state_t;

  typedef struct packed {
    logic               tbl_we;
    logic [NODE_W-1:0]  tbl_wnode;
    logic [LVL_W-1:0]   tbl_wlvl;
    logic [NODE_W-1:0]  tbl_wdata;
    logic [NODE_W-1:0]  tbl_rnode;
    logic [LVL_W-1:0]   tbl_rlvl;
    logic               dep_we;
    logic [NODE_W-1:0]  dep_wnode;
    logic [DEPTH_W-1:0] dep_wdata;
    logic [NODE_W-1:0]  dep_rnode;
  } mem_req_t;

  typedef struct packed {
    logic [NODE_W-1:0]  tbl_rdata;
    logic [DEPTH_W-1:0] dep_rdata;
  } mem_rsp_t;

endpackage

[sv/lcabl_mem.sv]
// ancestor table and depth memories, one write and one registered read each
// depends on lcabl_pkg
module lcabl_mem import lcabl_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  localparam int ROWS     = (NODE_COUNT < (1 << NODE_W)) ? NODE_COUNT : (1 << NODE_W);
  localparam int RW       = $clog2(ROWS);
  localparam int LW       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int TBL_DEPTH = ROWS << LW;

  logic [NODE_W-1:0]  tbl_mem [TBL_DEPTH];
  logic [DEPTH_W-1:0] dep_mem [ROWS];

  logic [RW+LW-1:0] tbl_waddr;
  logic [RW+LW-1:0] tbl_raddr;

  logic [NODE_W-1:0]  tbl_rdata;
  logic [DEPTH_W-1:0] dep_rdata;

  assign tbl_waddr = {req.tbl_wnode[RW-1:0], req.tbl_wlvl[LW-1:0]};
  assign tbl_raddr = {req.tbl_rnode[RW-1:0], req.tbl_rlvl[LW-1:0]};

  assign rsp = '{tbl_rdata: tbl_rdata, dep_rdata: dep_rdata};

  always_ff @(posedge clk) begin
    if (req.tbl_we) begin
      tbl_mem[tbl_waddr] <= req.tbl_wdata;
    end
    tbl_rdata <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.dep_we) begin
      dep_mem[req.dep_wnode[RW-1:0]] <= req.dep_wdata;
    end
    dep_rdata <= dep_mem[req.dep_rnode[RW-1:0]];
  end

endmodule

[sv/lcabl_ctrl.sv]
// sequencer for attach and query items, driving one table lookup per step
// depends on lcabl_pkg
module lcabl_ctrl import lcabl_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  input  logic              out_free,
  output logic              res_valid,
  output logic [NODE_W-1:0] res_node,
  output mem_req_t          req,
  input  mem_rsp_t          rsp
);

  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LIFT_LEVELS - 1);

  state_t              state, state_next;
  logic [LVL_W-1:0]    lvl, lvl_next;
  logic [NODE_W-1:0]   ra, ra_next;
  logic [NODE_W-1:0]   rb, rb_next;
  logic [NODE_W-1:0]   tnode, tnode_next;
  logic [NODE_W-1:0]   pa, pa_next;
  logic [DEPTH_W-1:0]  da, da_next;
  logic [DIFF_W-1:0]   k, k_next;
  logic [NODE_W-1:0]   res, res_next;
  logic                emit, emit_next;
  logic                lvl_last;
  logic                in_range;

  assign lvl_last = (lvl == LAST_LVL);
  assign in_range = (32'(node_a) < NODE_COUNT) && (32'(node_b) < NODE_COUNT);
  assign res_node = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      lvl   <= '0;
      emit  <= 1'b0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      emit  <= emit_next;
    end
  end

  always_ff @(posedge clk) begin
    ra    <= ra_next;
    rb    <= rb_next;
    tnode <= tnode_next;
    pa    <= pa_next;
    da    <= da_next;
    k     <= k_next;
    res   <= res_next;
  end

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    ra_next    = ra;
    rb_next    = rb;
    tnode_next = tnode;
    pa_next    = pa;
    da_next    = da;
    k_next     = k;
    res_next   = res;
    emit_next  = emit;
    req        = '0;
    in_stall   = 1'b1;
    res_valid  = 1'b0;

    // a pending result goes out as soon as the output register can take it
    if (emit) begin
      in_stall = 1'b1;
      if (out_free) begin
        res_valid  = 1'b1;
        emit_next  = 1'b0;
        state_next = ST_IDLE;
      end
    end else begin
      case (state)
        ST_INIT: begin
          // root row and root depth cleared one level a cycle
          req.tbl_we    = 1'b1;
          req.tbl_wnode = '0;
          req.tbl_wlvl  = lvl;
          req.tbl_wdata = '0;
          req.dep_we    = 1'b1;
          req.dep_wnode = '0;
          req.dep_wdata = '0;
          if (lvl_last) begin
            lvl_next   = '0;
            state_next = ST_IDLE;
          end else begin
            lvl_next = lvl + 1'b1;
          end
        end
        ST_IDLE: begin
          in_stall = 1'b0;
          if (in_valid) begin
            ra_next = node_a;
            rb_next = node_b;
            if (cmd == CMD_ATTACH) begin
              if (in_range) begin
                state_next = ST_ATT_RD;
              end
            end else if (in_range) begin
              state_next = ST_Q_DA;
            end else begin
              res_next  = '0;
              emit_next = 1'b1;
            end
          end
        end
        ST_ATT_RD: begin
          req.dep_rnode = rb;
          state_next    = ST_ATT_WR;
        end
        ST_ATT_WR: begin
          req.dep_we    = 1'b1;
          req.dep_wnode = ra;
          req.dep_wdata = (rsp.dep_rdata == DEPTH_MAX) ? DEPTH_MAX
                                                       : rsp.dep_rdata + 1'b1;
          req.tbl_we    = 1'b1;
          req.tbl_wnode = ra;
          req.tbl_wlvl  = '0;
          req.tbl_wdata = rb;
          tnode_next    = rb;
          if (lvl_last) begin
            state_next = ST_IDLE;
          end else begin
            lvl_next   = LVL_W'(1);
            state_next = ST_ATT_LOOK;
          end
        end
        ST_ATT_LOOK: begin
          req.tbl_rnode = tnode;
          req.tbl_rlvl  = lvl - 1'b1;
          state_next    = ST_ATT_FILL;
        end
        ST_ATT_FILL: begin
          req.tbl_we    = 1'b1;
          req.tbl_wnode = ra;
          req.tbl_wlvl  = lvl;
          req.tbl_wdata = rsp.tbl_rdata;
          tnode_next    = rsp.tbl_rdata;
          if (lvl_last) begin
            lvl_next   = '0;
            state_next = ST_IDLE;
          end else begin
            lvl_next   = lvl + 1'b1;
            state_next = ST_ATT_LOOK;
          end
        end
        ST_Q_DA: begin
          req.dep_rnode = ra;
          state_next    = ST_Q_DB;
        end
        ST_Q_DB: begin
          da_next       = rsp.dep_rdata;
          req.dep_rnode = rb;
          state_next    = ST_Q_SWAP;
        end
        ST_Q_SWAP: begin
          // deeper node goes to ra, depth difference into k
          if (da < rsp.dep_rdata) begin
            ra_next = rb;
            rb_next = ra;
            k_next  = DIFF_W'(rsp.dep_rdata - da);
          end else begin
            k_next  = DIFF_W'(da - rsp.dep_rdata);
          end
          lvl_next   = LAST_LVL;
          state_next = ST_Q_LIFT;
        end
        ST_Q_LIFT: begin
          if (k[lvl]) begin
            req.tbl_rnode = ra;
            req.tbl_rlvl  = lvl;
            state_next    = ST_Q_LIFTD;
          end else if (lvl == '0) begin
            state_next = ST_Q_EQ;
          end else begin
            lvl_next = lvl - 1'b1;
          end
        end
        ST_Q_LIFTD: begin
          ra_next = rsp.tbl_rdata;
          if (lvl == '0) begin
            state_next = ST_Q_EQ;
          end else begin
            lvl_next   = lvl - 1'b1;
            state_next = ST_Q_LIFT;
          end
        end
        ST_Q_EQ: begin
          if (ra == rb) begin
            res_next  = ra;
            emit_next = 1'b1;
          end else begin
            lvl_next   = LAST_LVL;
            state_next = ST_Q_PA;
          end
        end
        ST_Q_PA: begin
          req.tbl_rnode = ra;
          req.tbl_rlvl  = lvl;
          state_next    = ST_Q_PB;
        end
        ST_Q_PB: begin
          pa_next       = rsp.tbl_rdata;
          req.tbl_rnode = rb;
          req.tbl_rlvl  = lvl;
          state_next    = ST_Q_CMP;
        end
        ST_Q_CMP: begin
          if (pa != rsp.tbl_rdata) begin
            ra_next = pa;
            rb_next = rsp.tbl_rdata;
          end
          if (lvl == '0) begin
            state_next = ST_Q_FIN;
          end else begin
            lvl_next   = lvl - 1'b1;
            state_next = ST_Q_PA;
          end
        end
        ST_Q_FIN: begin
          // parent of the lifted node, read here and taken next cycle
          req.tbl_rnode = ra;
          req.tbl_rlvl  = '0;
          state_next    = ST_Q_RES;
        end
        ST_Q_RES: begin
          res_next  = rsp.tbl_rdata;
          emit_next = 1'b1;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/lca_binary_lifting.sv]
// top level of the lowest common ancestor block: sequencer, memories and
// output register; depends on lcabl_pkg, lcabl_mem and lcabl_ctrl
//
// usage
//   input channel: in_valid / in_stall with cmd, node_a, node_b. cmd attach
//   places node_a under node_b (the parent must already be in the tree);
//   cmd query asks for the lowest common ancestor of node_a and node_b
//   output channel: out_valid / out_stall with ancestor, one transfer per
//   query and none per attach
//   an attach does one depth lookup, writes the depth and level 0, then one
//   ancestor-table read and write per further level through the table ports
//   a query reads both depths, then lifts the deeper node one table read per
//   set bit of the depth difference; when one node is an ancestor of the
//   other it answers with the lifted node, else it reads both parents per
//   level and one last parent; every step waits on the one table read port.
//   an out-of-range query answers 0. after reset the root row of the table
//   and the root depth are cleared, one level a cycle, while in_stall is high
//   the result sits in an output register; the next item is taken while it
//   waits, and only a second result waits in the sequencer for out_stall
//   to drop
module lca_binary_lifting import lcabl_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] ancestor
);

  mem_req_t          req;
  mem_rsp_t          rsp;
  logic              out_free;
  logic              res_valid;
  logic [NODE_W-1:0] res_node;

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid || !out_stall;

  lcabl_ctrl #(
    .NODE_COUNT  (NODE_COUNT),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .node_a    (node_a),
    .node_b    (node_b),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_node  (res_node),
    .req       (req),
    .rsp       (rsp)
  );

  lcabl_mem #(
    .NODE_COUNT  (NODE_COUNT),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // output register, valid cleared once its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      ancestor <= res_node;
    end
  end

endmodule
